### src/assert_macros.svh
// Assertion helpers shared by the deframer modules.
// Each use names its own label; clk and rst of the calling module are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, cond)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

### src/sdrd_pkg.sv
`default_nettype none

package sdrd_pkg;

  // Record framing
  localparam int REC_LEN   = 16;
  localparam int HELD_W    = $clog2(REC_LEN);
  localparam int START_BIT = 7;
  localparam int N_AXES    = 3;
  localparam int POS_BASE  = 1;   // first byte of x position
  localparam int ANG_BASE  = 10;  // first byte of pitch

  // Raw field widths
  localparam int GROUP_W = 7;
  localparam int POS_W   = 3 * GROUP_W;
  localparam int ANG_W   = 2 * GROUP_W;

  // Output widths
  localparam int POS_OUT_W = 28;
  localparam int ANG_OUT_W = 25;
  localparam int FRAC_W    = 13;  // scale factor 8192

  // Position scaling: round(v * 8192 / 125) = floor((8192 v + 62) / 125)
  localparam int POS_DIV          = 125;
  localparam int POS_ROUND        = 62;
  localparam int POS_RECIP_W      = 22;
  localparam int POS_RECIP_SHIFT  = 28;
  localparam logic [POS_RECIP_W-1:0] POS_RECIP = POS_RECIP_W'((1 << POS_RECIP_SHIFT) / POS_DIV);
  localparam int POS_PROD_W       = POS_W + POS_RECIP_W;
  localparam int POS_QUO_W        = 14;  // |v| / 125 <= 8388
  localparam int POS_REM_W        = 7;   // remainder below 125
  localparam int POS_REM_WIDE_W   = 8;   // remainder before correction, below 250
  localparam int POS_MAG_W        = POS_QUO_W + FRAC_W;

  // Angle scaling: round(v * 8192 / 5) = floor((8192 v + 2) / 5)
  localparam int ANG_DIV          = 5;
  localparam int ANG_ROUND        = 2;
  localparam int ANG_RECIP_W      = 18;
  localparam int ANG_RECIP_SHIFT  = 20;
  localparam logic [ANG_RECIP_W-1:0] ANG_RECIP = ANG_RECIP_W'((1 << ANG_RECIP_SHIFT) / ANG_DIV);
  localparam int ANG_PROD_W       = ANG_W + ANG_RECIP_W;
  localparam int ANG_QUO_W        = 12;  // v / 5 <= 3276
  localparam int ANG_REM_W        = 3;   // remainder below 5
  localparam int ANG_REM_WIDE_W   = 4;   // remainder before correction, below 10

  // Record queue
  localparam int QUEUE_DEPTH = 2;

  // Fraction tables: scaled, rounded remainder of the constant division
  typedef logic [FRAC_W-1:0] pos_frac_tbl_t [POS_DIV];
  typedef logic [FRAC_W-1:0] ang_frac_tbl_t [ANG_DIV];

  function automatic pos_frac_tbl_t make_pos_frac();
    pos_frac_tbl_t t;
    for (int i = 0; i < POS_DIV; i++) begin
      t[i] = FRAC_W'((i * (1 << FRAC_W) + POS_ROUND) / POS_DIV);
    end
    return t;
  endfunction

  function automatic ang_frac_tbl_t make_ang_frac();
    ang_frac_tbl_t t;
    for (int i = 0; i < ANG_DIV; i++) begin
      t[i] = FRAC_W'((i * (1 << FRAC_W) + ANG_ROUND) / ANG_DIV);
    end
    return t;
  endfunction

  localparam pos_frac_tbl_t POS_FRAC = make_pos_frac();
  localparam ang_frac_tbl_t ANG_FRAC = make_ang_frac();

  // Channel payloads
  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]                  buttons;
    logic signed [POS_OUT_W-1:0] pos_x;
    logic signed [POS_OUT_W-1:0] pos_y;
    logic signed [POS_OUT_W-1:0] pos_z;
    logic [ANG_OUT_W-1:0]        angle_pitch;
    logic [ANG_OUT_W-1:0]        angle_yaw;
    logic [ANG_OUT_W-1:0]        angle_roll;
  } out_item_t;

  // One framed record, raw fields already gathered
  typedef struct packed {
    logic [7:0]                     buttons;
    logic [N_AXES-1:0][POS_W-1:0]   pos_raw;
    logic [N_AXES-1:0][ANG_W-1:0]   ang_raw;
  } record_t;

  typedef struct packed {
    logic    valid;
    record_t rec;
  } push_t;

endpackage

`default_nettype wire

### src/sdrd_stream_if.sv
`default_nettype none

// Valid/ready channel; an item moves when both are high at a clock edge
interface sdrd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/sdrd_front.sv
`default_nettype none

`include "assert_macros.svh"

module sdrd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  sdrd_stream_if.sink          serial,
  input  wire logic            full,
  output sdrd_pkg::push_t      push
);

  localparam logic [sdrd_pkg::HELD_W-1:0] LAST_HELD = sdrd_pkg::HELD_W'(sdrd_pkg::REC_LEN - 1);

  logic [sdrd_pkg::HELD_W-1:0] bytes_held;  // 0 means no record open
  logic [7:0]                  store [sdrd_pkg::REC_LEN-1];
  logic [7:0]                  rec_bytes [sdrd_pkg::REC_LEN];
  logic                        accept;
  logic                        start;

  // A byte is taken whenever the queue has room for a finished record
  assign serial.ready = !full;
  assign accept       = serial.valid && serial.ready;
  assign start        = serial.data.rx_byte[sdrd_pkg::START_BIT];

  // Record byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held <= '0;
    end else if (accept) begin
      if (start) begin
        bytes_held <= sdrd_pkg::HELD_W'(1);
      end else if (bytes_held == '0) begin
        bytes_held <= '0;
      end else if (bytes_held == LAST_HELD) begin
        bytes_held <= '0;
      end else begin
        bytes_held <= bytes_held + 1'b1;
      end
    end
  end

  // Byte store; the last byte goes straight into the record
  always_ff @(posedge clk) begin
    if (accept) begin
      if (start) begin
        store[0] <= serial.data.rx_byte;
      end else if (bytes_held != '0 && bytes_held != LAST_HELD) begin
        store[bytes_held] <= serial.data.rx_byte;
      end
    end
  end

  // Gather raw fields from the finished record
  always_comb begin
    for (int i = 0; i < sdrd_pkg::REC_LEN - 1; i++) begin
      rec_bytes[i] = store[i];
    end
    rec_bytes[sdrd_pkg::REC_LEN-1] = serial.data.rx_byte;

    push.valid       = accept && !start && bytes_held == LAST_HELD;
    push.rec.buttons = rec_bytes[0];
    for (int k = 0; k < sdrd_pkg::N_AXES; k++) begin
      push.rec.pos_raw[k] = {rec_bytes[sdrd_pkg::POS_BASE + 3*k][sdrd_pkg::GROUP_W-1:0],
                             rec_bytes[sdrd_pkg::POS_BASE + 3*k + 1][sdrd_pkg::GROUP_W-1:0],
                             rec_bytes[sdrd_pkg::POS_BASE + 3*k + 2][sdrd_pkg::GROUP_W-1:0]};
      push.rec.ang_raw[k] = {rec_bytes[sdrd_pkg::ANG_BASE + 2*k][sdrd_pkg::GROUP_W-1:0],
                             rec_bytes[sdrd_pkg::ANG_BASE + 2*k + 1][sdrd_pkg::GROUP_W-1:0]};
    end
  end

  // A start byte always opens a fresh record holding one byte
  `ASSERT_NEXT(a_start_opens, accept && start, bytes_held == sdrd_pkg::HELD_W'(1))

endmodule

`default_nettype wire

### src/sdrd_queue.sv
`default_nettype none

`include "assert_macros.svh"

module sdrd_queue #(
  parameter int DEPTH = sdrd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sdrd_pkg::push_t   push,
  input  wire logic              pop,
  output sdrd_pkg::record_t      head,
  output logic                   full,
  output logic                   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  sdrd_pkg::record_t  entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.rec;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_push_grows, push.valid && !pop, count == $past(count) + 1'b1)

endmodule

`default_nettype wire

### src/sdrd_back.sv
`default_nettype none

`include "assert_macros.svh"

module sdrd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sdrd_pkg::record_t  head,
  input  wire logic               empty,
  output logic                    pop,
  sdrd_stream_if.source           pose
);

  localparam int NA = sdrd_pkg::N_AXES;

  // Stage valid bits, stage 1 first; bit 4 is the output register
  logic [4:0] v;
  logic       advance;

  // Stage 1: magnitudes
  logic [7:0]                          s1_buttons;
  logic [NA-1:0]                       s1_neg;
  logic [sdrd_pkg::POS_W-1:0]          s1_pmag [NA];
  logic [sdrd_pkg::ANG_W-1:0]          s1_amag [NA];
  // Stage 2: reciprocal products
  logic [7:0]                          s2_buttons;
  logic [NA-1:0]                       s2_neg;
  logic [sdrd_pkg::POS_W-1:0]          s2_pmag [NA];
  logic [sdrd_pkg::ANG_W-1:0]          s2_amag [NA];
  logic [sdrd_pkg::POS_PROD_W-1:0]     s2_pprod [NA];
  logic [sdrd_pkg::ANG_PROD_W-1:0]     s2_aprod [NA];
  // Stage 3: quotient estimates and remainders
  logic [7:0]                          s3_buttons;
  logic [NA-1:0]                       s3_neg;
  logic [sdrd_pkg::POS_QUO_W-1:0]      s3_pquo [NA];
  logic [sdrd_pkg::POS_REM_WIDE_W-1:0] s3_prem [NA];
  logic [sdrd_pkg::ANG_QUO_W-1:0]      s3_aquo [NA];
  logic [sdrd_pkg::ANG_REM_WIDE_W-1:0] s3_arem [NA];
  // Stage 4: corrected quotients
  logic [7:0]                          s4_buttons;
  logic [NA-1:0]                       s4_neg;
  logic [sdrd_pkg::POS_QUO_W-1:0]      s4_pquo [NA];
  logic [sdrd_pkg::POS_REM_W-1:0]      s4_prem [NA];
  logic [sdrd_pkg::ANG_QUO_W-1:0]      s4_aquo [NA];
  logic [sdrd_pkg::ANG_REM_W-1:0]      s4_arem [NA];
  // Output register
  logic [7:0]                          out_buttons;
  logic [sdrd_pkg::POS_OUT_W-1:0]      out_pos [NA];
  logic [sdrd_pkg::ANG_OUT_W-1:0]      out_ang [NA];

  // Combinational per-stage values
  logic [sdrd_pkg::POS_W-1:0]          prem_full [NA];
  logic [sdrd_pkg::ANG_W-1:0]          arem_full [NA];
  logic [sdrd_pkg::POS_MAG_W-1:0]      pmag_q [NA];

  // The whole pipeline moves unless a finished item is held at the output
  assign advance    = !v[4] || pose.ready;
  assign pop        = advance && !empty;
  assign pose.valid = v[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (advance) begin
      v <= {v[3:0], pop};
    end
  end

  // Remainder after the quotient estimate, and the scaled magnitude
  always_comb begin
    for (int k = 0; k < NA; k++) begin
      prem_full[k] = s2_pmag[k] -
        sdrd_pkg::POS_W'(s2_pprod[k][sdrd_pkg::POS_RECIP_SHIFT +: sdrd_pkg::POS_QUO_W]
                         * sdrd_pkg::POS_DIV);
      arem_full[k] = s2_amag[k] -
        sdrd_pkg::ANG_W'(s2_aprod[k][sdrd_pkg::ANG_RECIP_SHIFT +: sdrd_pkg::ANG_QUO_W]
                         * sdrd_pkg::ANG_DIV);
      pmag_q[k] = {s4_pquo[k], sdrd_pkg::POS_FRAC[s4_prem[k]]};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_buttons <= head.buttons;
      s2_buttons <= s1_buttons;
      s3_buttons <= s2_buttons;
      s4_buttons <= s3_buttons;
      out_buttons <= s4_buttons;
      s2_neg <= s1_neg;
      s3_neg <= s2_neg;
      s4_neg <= s3_neg;
      for (int k = 0; k < NA; k++) begin
        // sign and magnitude of the position
        s1_neg[k]  <= head.pos_raw[k][sdrd_pkg::POS_W-1];
        s1_pmag[k] <= head.pos_raw[k][sdrd_pkg::POS_W-1] ?
                      ('0 - head.pos_raw[k]) : head.pos_raw[k];
        s1_amag[k] <= head.ang_raw[k];

        // multiply by the reciprocal of the divisor
        s2_pmag[k]  <= s1_pmag[k];
        s2_amag[k]  <= s1_amag[k];
        s2_pprod[k] <= sdrd_pkg::POS_PROD_W'(s1_pmag[k]) *
                       sdrd_pkg::POS_PROD_W'(sdrd_pkg::POS_RECIP);
        s2_aprod[k] <= sdrd_pkg::ANG_PROD_W'(s1_amag[k]) *
                       sdrd_pkg::ANG_PROD_W'(sdrd_pkg::ANG_RECIP);

        // estimate is exact or one short
        s3_pquo[k] <= s2_pprod[k][sdrd_pkg::POS_RECIP_SHIFT +: sdrd_pkg::POS_QUO_W];
        s3_prem[k] <= prem_full[k][sdrd_pkg::POS_REM_WIDE_W-1:0];
        s3_aquo[k] <= s2_aprod[k][sdrd_pkg::ANG_RECIP_SHIFT +: sdrd_pkg::ANG_QUO_W];
        s3_arem[k] <= arem_full[k][sdrd_pkg::ANG_REM_WIDE_W-1:0];

        // one correction step
        if (s3_prem[k] >= sdrd_pkg::POS_REM_WIDE_W'(sdrd_pkg::POS_DIV)) begin
          s4_pquo[k] <= s3_pquo[k] + 1'b1;
          s4_prem[k] <= sdrd_pkg::POS_REM_W'(s3_prem[k] -
                        sdrd_pkg::POS_REM_WIDE_W'(sdrd_pkg::POS_DIV));
        end else begin
          s4_pquo[k] <= s3_pquo[k];
          s4_prem[k] <= s3_prem[k][sdrd_pkg::POS_REM_W-1:0];
        end
        if (s3_arem[k] >= sdrd_pkg::ANG_REM_WIDE_W'(sdrd_pkg::ANG_DIV)) begin
          s4_aquo[k] <= s3_aquo[k] + 1'b1;
          s4_arem[k] <= sdrd_pkg::ANG_REM_W'(s3_arem[k] -
                        sdrd_pkg::ANG_REM_WIDE_W'(sdrd_pkg::ANG_DIV));
        end else begin
          s4_aquo[k] <= s3_aquo[k];
          s4_arem[k] <= s3_arem[k][sdrd_pkg::ANG_REM_W-1:0];
        end

        // quotient times 8192 plus the rounded fraction, sign restored
        out_pos[k] <= s4_neg[k] ? ('0 - sdrd_pkg::POS_OUT_W'(pmag_q[k]))
                                : sdrd_pkg::POS_OUT_W'(pmag_q[k]);
        out_ang[k] <= {s4_aquo[k], sdrd_pkg::ANG_FRAC[s4_arem[k]]};
      end
    end
  end

  always_comb begin
    pose.data.buttons     = out_buttons;
    pose.data.pos_x       = out_pos[0];
    pose.data.pos_y       = out_pos[1];
    pose.data.pos_z       = out_pos[2];
    pose.data.angle_pitch = out_ang[0];
    pose.data.angle_yaw   = out_ang[1];
    pose.data.angle_roll  = out_ang[2];
  end

  // With the output free, the last stage takes what the one before held
  `ASSERT_NEXT(a_pipe_shift, !v[4] || pose.ready, v[4] == $past(v[3]))

endmodule

`default_nettype wire

### src/six_dof_record_deframer_top.sv
// Six-degree-of-freedom tracker record deframer. Serial bytes come in on the
// serial channel, one item per byte, and are taken one per clock cycle. A byte
// with bit 7 set opens a 16-byte record (restarting any partial one); other
// bytes are dropped while no record is open. Each completed record yields one
// item on the pose channel: the button byte, x/y/z as signed Q.16 of raw/1000
// and pitch/yaw/roll as unsigned Q.16 of raw/40, all rounded to nearest. The
// result is registered in the record queue and then in each of the five stages
// of the back end's constant-division pipeline. Serial bytes are only held off
// while the record queue (QUEUE_DEPTH records) is full, which happens only when
// the pose sink stalls for a long time.
`default_nettype none

module six_dof_record_deframer_top #(
  parameter int QUEUE_DEPTH = sdrd_pkg::QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  sdrd_stream_if.sink    serial,
  sdrd_stream_if.source  pose
);

  sdrd_pkg::push_t   push;
  sdrd_pkg::record_t head;
  logic              full;
  logic              empty;
  logic              pop;

  // Framing of incoming bytes
  sdrd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .serial (serial),
    .full   (full),
    .push   (push)
  );

  // Finished records waiting for decode
  sdrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (full),
    .empty (empty)
  );

  // Scaling pipeline and output register
  sdrd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .pose  (pose)
  );

endmodule

`default_nettype wire

### tb/sdrd_pose_checker.sv
// Watches the serial and pose channels, rebuilds records from accepted bytes,
// predicts each decoded pose item and compares it with what the block emits.
module sdrd_pose_checker
  import sdrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fails,
  output int        pending
);

  // Framing state of the predictor
  logic [4:0] frame_count;
  logic [7:0] frame_bytes [REC_LEN];

  out_item_t expected_poses [$];
  out_item_t want;

  initial begin
    fails = 0;
    pending = 0;
    frame_count = '0;
    for (int i = 0; i < REC_LEN; i++) frame_bytes[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    fails++;
  endtask

  task automatic check_field(input string name, input longint got, input longint exp_val);
    if (got != exp_val) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
    end
  endtask

  // round(raw * 65536 / 1000) on a 21-bit two's complement value
  function automatic logic signed [POS_OUT_W-1:0] pos_to_q16(input logic [POS_W-1:0] raw);
    longint mag;
    longint q;
    mag = raw[POS_W-1] ? (longint'(1) << POS_W) - longint'(raw) : longint'(raw);
    q = (2 * mag * 8192 + 125) / 250;
    if (raw[POS_W-1]) q = -q;
    return POS_OUT_W'(q);
  endfunction

  // round(raw * 65536 / 40) on a 14-bit unsigned value
  function automatic logic [ANG_OUT_W-1:0] ang_to_q16(input logic [ANG_W-1:0] raw);
    longint n;
    n = longint'(raw) * 8192;
    return ANG_OUT_W'((2 * n + 5) / 10);
  endfunction

  function automatic logic [POS_W-1:0] gather_pos(input int a);
    return {frame_bytes[a][GROUP_W-1:0], frame_bytes[a+1][GROUP_W-1:0],
            frame_bytes[a+2][GROUP_W-1:0]};
  endfunction

  function automatic logic [ANG_W-1:0] gather_ang(input int b);
    return {frame_bytes[b][GROUP_W-1:0], frame_bytes[b+1][GROUP_W-1:0]};
  endfunction

  // One accepted serial byte; a completed record queues its pose
  task automatic take_byte(input logic [7:0] b);
    out_item_t pose;
    if (b[START_BIT]) begin
      frame_bytes[0] = b;
      frame_count = 5'd1;
    end else if (frame_count != 0) begin
      frame_bytes[frame_count[3:0]] = b;
      frame_count = frame_count + 5'd1;
      if (frame_count == REC_LEN) begin
        frame_count = '0;
        pose.buttons     = frame_bytes[0];
        pose.pos_x       = pos_to_q16(gather_pos(POS_BASE));
        pose.pos_y       = pos_to_q16(gather_pos(POS_BASE + 3));
        pose.pos_z       = pos_to_q16(gather_pos(POS_BASE + 6));
        pose.angle_pitch = ang_to_q16(gather_ang(ANG_BASE));
        pose.angle_yaw   = ang_to_q16(gather_ang(ANG_BASE + 2));
        pose.angle_roll  = ang_to_q16(gather_ang(ANG_BASE + 4));
        expected_poses.push_back(pose);
      end
    end
  endtask

  // Compare emitted poses first, then account for the byte taken this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_poses.size() == 0) begin
          report_mismatch($sformatf("unexpected pose item, buttons %0h", out_data.buttons));
        end else begin
          want = expected_poses.pop_front();
          check_field("buttons", longint'(out_data.buttons), longint'(want.buttons));
          check_field("pos_x", longint'(out_data.pos_x), longint'(want.pos_x));
          check_field("pos_y", longint'(out_data.pos_y), longint'(want.pos_y));
          check_field("pos_z", longint'(out_data.pos_z), longint'(want.pos_z));
          check_field("angle_pitch", longint'(out_data.angle_pitch),
                      longint'(want.angle_pitch));
          check_field("angle_yaw", longint'(out_data.angle_yaw), longint'(want.angle_yaw));
          check_field("angle_roll", longint'(out_data.angle_roll), longint'(want.angle_roll));
        end
      end
      if (in_valid && in_ready) take_byte(in_data.rx_byte);
      pending = expected_poses.size();
    end
  end

endmodule

### tb/tb_six_dof_record_deframer_top.sv
module tb_six_dof_record_deframer_top;
  import sdrd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int  fail_count;
  int  pending_poses;
  int  idle_cycles = 0;
  int  record_bytes_sent = 0;
  bit  steady = 1'b0;
  bit  hold_go = 1'b0;

  // Opening bytes: dropped bytes, a restarted partial record, a record with
  // extreme fields, then a data byte after completion
  logic [7:0] directed_bytes [21] = '{
    8'h00, 8'h7F,
    8'hC3, 8'h11,
    8'hFF, 8'h3F, 8'h7F, 8'h7F, 8'h40, 8'h00, 8'h00, 8'h7F, 8'h7F, 8'h7F,
    8'h7F, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h01,
    8'h2A
  };

  sdrd_stream_if #(.T(in_item_t))  serial_ch ();
  sdrd_stream_if #(.T(out_item_t)) pose_ch ();

  six_dof_record_deframer_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .serial (serial_ch),
    .pose   (pose_ch)
  );

  sdrd_pose_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (serial_ch.valid),
    .in_ready  (serial_ch.ready),
    .in_data   (serial_ch.data),
    .out_valid (pose_ch.valid),
    .out_ready (pose_ch.ready),
    .out_data  (pose_ch.data),
    .fails     (fail_count),
    .pending   (pending_poses)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (serial_ch.valid && serial_ch.ready) || (pose_ch.valid && pose_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL six_dof_record_deframer_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly zero or short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // 7-bit group biased toward sign and range edges
  function automatic logic [6:0] rand_group();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 7'h00;
      1: return 7'h7F;
      2: return 7'h40;
      3: return 7'h3F;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic drive_byte(input logic [7:0] b);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      serial_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    serial_ch.valid <= 1'b1;
    serial_ch.data.rx_byte <= b;
    @(posedge clk);
    while (!serial_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Start byte followed by data_len random data bytes
  task automatic send_record(input int data_len);
    drive_byte({1'b1, 7'($urandom_range(0, 127))});
    for (int i = 0; i < data_len; i++) drive_byte({1'b0, rand_group()});
    record_bytes_sent += data_len + 1;
  endtask

  // Stop offering and wait for every expected pose
  task automatic drain_poses();
    serial_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_poses != 0) @(negedge clk);
  endtask

  // Mostly well-formed records, some broken ones and some noise
  task automatic random_traffic(input int target);
    int r;
    while (record_bytes_sent < target) begin
      steady = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 78) begin
        send_record(REC_LEN - 1);
      end else if (r < 90) begin
        send_record($urandom_range(0, REC_LEN - 2));
      end else if (r < 96) begin
        repeat ($urandom_range(1, 4)) drive_byte({1'b0, rand_group()});
      end else begin
        drive_byte(8'($urandom_range(0, 255)));
      end
    end
    steady = 1'b0;
  endtask

  // Serial source
  initial begin
    serial_ch.valid = 1'b0;
    serial_ch.data = '0;
    while (rst) @(negedge clk);
    @(negedge clk);

    foreach (directed_bytes[i]) drive_byte(directed_bytes[i]);
    drain_poses();

    random_traffic(700);
    drain_poses();

    // Back-to-back records while the pose side holds off
    hold_go = 1'b1;
    steady = 1'b1;
    repeat (8) send_record(REC_LEN - 1);
    steady = 1'b0;

    random_traffic(1600);
    drain_poses();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS six_dof_record_deframer_top");
    end else begin
      $display("FAIL six_dof_record_deframer_top");
    end
    $finish;
  end

  // Pose sink: random ready pattern, plus one long hold-off on request
  initial begin
    int r;
    int n;
    pose_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_go) begin
        pose_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_go = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          pose_ch.ready <= 1'b1;
          n = $urandom_range(1, 16);
        end else if (r < 62) begin
          pose_ch.ready <= 1'b1;
          n = $urandom_range(60, 150);
        end else if (r < 94) begin
          pose_ch.ready <= 1'b0;
          n = $urandom_range(1, 4);
        end else begin
          pose_ch.ready <= 1'b0;
          n = $urandom_range(20, 80);
        end
        // a hold-off request cuts the current phase short
        for (int i = 0; i < n; i++) begin
          @(negedge clk);
          if (hold_go) break;
        end
      end
    end
  end

endmodule
